// ===== hw/rtl/swmf_pkg.sv =====
// Shared widths, defaults and the link type between neighbouring window cells.
// No dependencies; used by swmf_cell and sliding_window_median_filter_unit.
package swmf_pkg;

  localparam int VAL_W          = 13;
  localparam int FILLED_W       = 3;
  localparam int WINDOW_DEFAULT = 5;

  localparam logic [VAL_W-1:0] MAX_DISTANCE_RESET = 13'd8190;

  // Handed from a cell to the one above it during an update.
  typedef struct packed {
    logic del_seen;  // an entry at or below this cell is being evicted
    logic b_valid;   // the cell holds a valid entry once the eviction is closed up
    logic b_gt;      // that entry is greater than the incoming sample
  } link_t;

endpackage

// ===== hw/rtl/swmf_cell.sv =====
// One cell of the sorted window: holds one entry with its ring slot tag.
// Depends on swmf_pkg for the value width and the neighbour link type.
module swmf_cell #(
  parameter int TAG_W = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic                       clear,
  input  logic                       evict,
  input  logic [TAG_W-1:0]           evict_tag,
  input  logic [swmf_pkg::VAL_W-1:0] ins_value,
  input  logic [TAG_W-1:0]           ins_tag,
  input  logic                       up_valid,
  input  logic [swmf_pkg::VAL_W-1:0] up_value,
  input  logic [TAG_W-1:0]           up_tag,
  input  swmf_pkg::link_t            lo_link,
  input  logic [swmf_pkg::VAL_W-1:0] lo_b_value,
  input  logic [TAG_W-1:0]           lo_b_tag,
  output logic                       own_valid,
  output logic [swmf_pkg::VAL_W-1:0] own_value,
  output logic [TAG_W-1:0]           own_tag,
  output swmf_pkg::link_t            hi_link,
  output logic [swmf_pkg::VAL_W-1:0] b_value,
  output logic [TAG_W-1:0]           b_tag,
  output logic [swmf_pkg::VAL_W-1:0] c_value
);
  import swmf_pkg::*;

  logic             a_valid;
  logic             del_here;
  logic             del_le;
  logic             b_valid;
  logic             b_gt;
  logic             c_valid;
  logic [TAG_W-1:0] c_tag;

  always_comb begin
    a_valid  = own_valid & ~clear;
    del_here = evict & a_valid & (own_tag == evict_tag);
    del_le   = lo_link.del_seen | del_here;
    // close up the evicted slot: take the neighbour above
    b_valid  = del_le ? (up_valid & ~clear) : a_valid;
    b_value  = del_le ? up_value : own_value;
    b_tag    = del_le ? up_tag : own_tag;
    b_gt     = b_valid & (b_value > ins_value);
    // insert: shift up where the entry below is larger
    if (lo_link.b_gt) begin
      c_value = lo_b_value;
      c_tag   = lo_b_tag;
    end else if (b_gt || !b_valid) begin
      c_value = ins_value;
      c_tag   = ins_tag;
    end else begin
      c_value = b_value;
      c_tag   = b_tag;
    end
    c_valid = b_valid | lo_link.b_valid;
    hi_link = '{del_seen: del_le, b_valid: b_valid, b_gt: b_gt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_valid <= 1'b0;
    end else if (load) begin
      own_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      own_value <= c_value;
      own_tag   <= c_tag;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_median_filter_unit.sv =====
// Sliding-window median filter for distance samples: top level.
// Depends on swmf_pkg and swmf_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: sample, timed_out,
//   restart. A timed-out sample, or one above max_distance, is stored as
//   max_distance. Restart empties the window before the sample is stored.
//   Output channel (out_valid/out_ready) returns median and filled for each
//   request: the median is element filled/2 of the ascending order of the
//   filled entries (upper middle for an even count).
//   Configuration: cfg_we writes cfg_data into max_distance at the clock
//   edge; write only while no request is in flight.
// Timing and throughput:
//   A result appears, registered, in the cycle after its request is taken;
//   one request per cycle is taken unless the output stalls. The window is
//   a sorted row of WINDOW cells, updated by local decisions of neighbours.
// Reset (rst, synchronous): window empty, ring slot and fill count zero,
//   max_distance back to 8190, output empty.
// Stall: the output register holds its result while out_ready is low and
//   in_ready drops, so no request is lost.
module sliding_window_median_filter_unit #(
  parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swmf_pkg::VAL_W-1:0]    sample,
  input  logic                          timed_out,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swmf_pkg::VAL_W-1:0]    median,
  output logic [swmf_pkg::FILLED_W-1:0] filled,
  input  logic                          cfg_we,
  input  logic [swmf_pkg::VAL_W-1:0]    cfg_data
);
  import swmf_pkg::*;

  localparam int TAG_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [TAG_W-1:0]  LAST_SLOT = TAG_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW);

  logic [VAL_W-1:0]  max_distance;
  logic [TAG_W-1:0]  write_position;
  logic [TAG_W-1:0]  write_position_next;
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_count_next;
  logic [TAG_W-1:0]  wp_eff;
  logic [FILL_W-1:0] fill_eff;
  logic              full;
  logic              accept;
  logic [VAL_W-1:0]  ins_value;
  logic [TAG_W-1:0]  mid_idx;

  // neighbour wiring; index WINDOW is the empty slot above the top cell
  logic              cell_valid [WINDOW+1];
  logic [VAL_W-1:0]  cell_value [WINDOW+1];
  logic [TAG_W-1:0]  cell_tag   [WINDOW+1];
  link_t             link       [WINDOW+1];
  logic [VAL_W-1:0]  b_value    [WINDOW+1];
  logic [TAG_W-1:0]  b_tag      [WINDOW+1];
  logic [VAL_W-1:0]  c_value    [WINDOW];

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  always_comb begin
    // clamp timed-out and over-range samples
    ins_value = (timed_out || (sample > max_distance)) ? max_distance : sample;
    // restart empties the window first
    wp_eff   = restart ? '0 : write_position;
    fill_eff = restart ? '0 : fill_count;
    full     = (fill_eff == FULL);
    write_position_next = (wp_eff == LAST_SLOT) ? '0 : wp_eff + TAG_W'(1);
    fill_count_next     = full ? fill_eff : fill_eff + FILL_W'(1);
    mid_idx             = TAG_W'(fill_count_next >> 1);
  end

  // below the bottom cell: nothing evicted, treat as a valid smaller entry
  assign link[0]    = '{del_seen: 1'b0, b_valid: 1'b1, b_gt: 1'b0};
  assign b_value[0] = '0;
  assign b_tag[0]   = '0;
  // above the top cell: always empty
  assign cell_valid[WINDOW] = 1'b0;
  assign cell_value[WINDOW] = '0;
  assign cell_tag[WINDOW]   = '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swmf_cell #(
      .TAG_W(TAG_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (accept),
      .clear     (restart),
      .evict     (full),
      .evict_tag (wp_eff),
      .ins_value (ins_value),
      .ins_tag   (wp_eff),
      .up_valid  (cell_valid[i+1]),
      .up_value  (cell_value[i+1]),
      .up_tag    (cell_tag[i+1]),
      .lo_link   (link[i]),
      .lo_b_value(b_value[i]),
      .lo_b_tag  (b_tag[i]),
      .own_valid (cell_valid[i]),
      .own_value (cell_value[i]),
      .own_tag   (cell_tag[i]),
      .hi_link   (link[i+1]),
      .b_value   (b_value[i+1]),
      .b_tag     (b_tag[i+1]),
      .c_value   (c_value[i])
    );
  end

  // hold ring position and fill count; advance on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      fill_count     <= '0;
      max_distance   <= MAX_DISTANCE_RESET;
    end else begin
      if (accept) begin
        write_position <= write_position_next;
        fill_count     <= fill_count_next;
      end
      if (cfg_we) begin
        max_distance <= cfg_data;
      end
    end
  end

  // output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median <= c_value[mid_idx];
      filled <= FILLED_W'(fill_count_next);
    end
  end

endmodule

// ===== dv/sliding_window_median_filter_unit_test.sv =====
// Self-checking testbench for sliding_window_median_filter_unit: a request driver,
// a result monitor with its own window predictor, and a stalling receiver.
// Depends on swmf_pkg and the filter RTL only.
module sliding_window_median_filter_unit_test;
  import swmf_pkg::*;

  localparam int WINDOW         = WINDOW_DEFAULT;
  localparam int IDLE_LIMIT     = 2000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD      = 80;    // receiver hold-off that backs up the block
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQS     = 105;
  localparam logic [VAL_W-1:0] VAL_TOP = {VAL_W{1'b1}};

  typedef struct {
    logic [VAL_W-1:0] sample;
    logic             timed_out;
    logic             restart;
  } dist_req_t;

  typedef struct {
    logic [VAL_W-1:0]    median;
    logic [FILLED_W-1:0] filled;
  } median_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [VAL_W-1:0]    sample = '0;
  logic                timed_out = 1'b0;
  logic                restart = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VAL_W-1:0]    median;
  logic [FILLED_W-1:0] filled;
  logic                cfg_we = 1'b0;
  logic [VAL_W-1:0]    cfg_data = '0;

  // Stimulus and scoreboard storage
  dist_req_t      pending_reqs[$];
  median_result_t expected_medians[$];
  int             mismatches = 0;
  int             idle_cycles = 0;
  logic           req_taken = 1'b0;   // request accepted at the last rising edge

  // Pacing controls, set by the sequence and read by driver and receiver
  logic full_rate = 1'b0;
  int   hold_asks = 0;

  // Predictor state: ring of stored distances, write slot, fill count, clamp
  logic [VAL_W-1:0] win_vals [WINDOW];
  int               ring_slot = 0;
  int               fill_cnt = 0;
  logic [VAL_W-1:0] clamp_mm = MAX_DISTANCE_RESET;

  sliding_window_median_filter_unit #(
    .WINDOW(WINDOW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .timed_out(timed_out),
    .restart  (restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .median   (median),
    .filled   (filled),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Store one request in the ring and return the median of the filled entries.
  function automatic median_result_t next_median(dist_req_t r);
    logic [VAL_W-1:0] stored;
    logic [VAL_W-1:0] sorted [WINDOW];
    logic [VAL_W-1:0] key;
    int               j;
    median_result_t   res;
    // Replace timed-out and over-range readings by the clamp value
    stored = (r.timed_out || r.sample > clamp_mm) ? clamp_mm : r.sample;
    if (r.restart) begin
      ring_slot = 0;
      fill_cnt  = 0;
    end
    win_vals[ring_slot] = stored;
    ring_slot = (ring_slot + 1) % WINDOW;
    if (fill_cnt < WINDOW) fill_cnt++;
    // Filled entries always sit at the bottom of the ring
    for (int i = 0; i < fill_cnt; i++) sorted[i] = win_vals[i];
    for (int i = 1; i < fill_cnt; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    res.median = sorted[fill_cnt / 2];
    res.filled = FILLED_W'(fill_cnt);
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random reading, biased towards the clamp boundary and small distances.
  function automatic dist_req_t random_req(int clamp);
    dist_req_t r;
    int        pick;
    int        v;
    pick = $urandom_range(0, 9);
    if (pick < 4) v = $urandom_range(0, 8191);
    else if (pick < 6) v = clamp + int'($urandom_range(0, 4)) - 2;
    else if (pick < 8) v = $urandom_range(0, 255);
    else v = $urandom_range(0, clamp);
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    r.sample    = VAL_W'(v);
    r.timed_out = ($urandom_range(0, 9) == 0);
    r.restart   = ($urandom_range(0, 15) == 0);
    return r;
  endfunction

  // Driver: present the next pending request once the current one is taken,
  // after a random gap. Valid and payload hold until the handshake.
  int send_gap = 0;
  always @(negedge clk) begin
    dist_req_t r;
    if (!rst && (!in_valid || req_taken)) begin
      if (in_valid) send_gap = full_rate ? 0 : pick_gap();
      if (send_gap == 0 && pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_valid  <= 1'b1;
        sample    <= r.sample;
        timed_out <= r.timed_out;
        restart   <= r.restart;
      end else begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random ready gaps, plus a long hold-off when the sequence asks,
  // so that the output register fills and the input backs up.
  int ready_gap = 0;
  int hold_left = 0;
  int holds_done = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_asks != holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (full_rate) begin
        out_ready <= 1'b1;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        ready_gap = pick_gap();
      end
    end
  end

  // Monitor: check results against the oldest prediction, predict each
  // accepted request, track register writes and watch for a hang.
  always @(posedge clk) begin
    median_result_t want;
    dist_req_t      seen;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (cfg_we) clamp_mm = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected result median %0d filled %0d", $time, median, filled);
          mismatches++;
        end else begin
          want = expected_medians.pop_front();
          if (median !== want.median) begin
            $display("%0t: median expected %0d, got %0d", $time, want.median, median);
            mismatches++;
          end
          if (filled !== want.filled) begin
            $display("%0t: filled expected %0d, got %0d", $time, want.filled, filled);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        seen.sample    = sample;
        seen.timed_out = timed_out;
        seen.restart   = restart;
        expected_medians.push_back(next_median(seen));
      end
      // Count only cycles where nothing moves
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("[sliding_window_median_filter_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic queue_req(input logic [VAL_W-1:0] s, input logic t, input logic rs);
    dist_req_t r;
    r.sample    = s;
    r.timed_out = t;
    r.restart   = rs;
    pending_reqs.push_back(r);
  endtask

  // Checked at the falling edge: the monitor has settled and the driver
  // cannot raise valid again once nothing is pending.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_medians.size() != 0);
  endtask

  // Write the clamp register only with the block empty.
  task automatic write_clamp(input logic [VAL_W-1:0] v);
    wait_drained();
    repeat (2) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int clamp;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Default clamp: boundary values, timeouts, wrap of the ring, restarts
    queue_req(13'd100, 1'b0, 1'b0);
    queue_req(VAL_TOP, 1'b0, 1'b0);          // over range, clamped
    queue_req(MAX_DISTANCE_RESET, 1'b0, 1'b0); // equal to clamp, kept
    queue_req(13'd0, 1'b1, 1'b0);            // timeout
    queue_req(13'd0, 1'b0, 1'b0);            // window now full
    queue_req(13'd50, 1'b0, 1'b0);           // overwrite oldest
    queue_req(13'd4095, 1'b0, 1'b0);
    queue_req(13'd4096, 1'b0, 1'b0);
    queue_req(13'd7000, 1'b0, 1'b1);         // restart: median is the new reading
    queue_req(13'd2730, 1'b0, 1'b0);
    queue_req(13'd5461, 1'b0, 1'b0);
    queue_req(13'd1, 1'b1, 1'b1);            // restart with timeout
    queue_req(13'd8189, 1'b0, 1'b0);
    queue_req(13'd0, 1'b0, 1'b1);
    queue_req(13'd3, 1'b0, 1'b0);

    // Clamp at zero: everything above zero collapses
    write_clamp(13'd0);
    queue_req(13'd0, 1'b0, 1'b1);
    queue_req(13'd1, 1'b0, 1'b0);
    queue_req(VAL_TOP, 1'b1, 1'b0);

    // Clamp at the top: nothing is over range, a timeout stores the top
    write_clamp(VAL_TOP);
    queue_req(VAL_TOP, 1'b0, 1'b1);
    queue_req(13'd0, 1'b1, 1'b0);
    queue_req(13'd0, 1'b0, 1'b0);
    queue_req(13'd4096, 1'b0, 1'b0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       clamp = 8191;
        1:       clamp = 0;
        2:       clamp = 1000;
        4:       clamp = MAX_DISTANCE_RESET;
        default: clamp = $urandom_range(0, 8191);
      endcase
      write_clamp(VAL_W'(clamp));
      // One phase back to back, one with a long receiver hold-off
      full_rate <= (phase == 3);
      if (phase == 2) hold_asks <= hold_asks + 1;
      repeat (PHASE_REQS) pending_reqs.push_back(random_req(clamp));
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && expected_medians.size() == 0) begin
      $display("[sliding_window_median_filter_unit] OK");
    end else begin
      $display("[sliding_window_median_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
